// ===== design/ts_header_check_continuity_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the transport stream header checker
// Each macro expands to a labelled concurrent assertion, or to nothing in
// synthesis.
// ----------------------------------------------------------------------------
`ifndef TS_HEADER_CHECK_CONTINUITY_MACROS_SVH
`define TS_HEADER_CHECK_CONTINUITY_MACROS_SVH

`ifndef SYNTHESIS
`define TSHCC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tshcc assertion failed");
`define TSHCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tshcc assertion failed");
`else
`define TSHCC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define TSHCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/tshcc_pkg.sv =====
// ----------------------------------------------------------------------------
// tshcc_pkg
// Shared types and constants for the transport stream header checker.
// ----------------------------------------------------------------------------
package tshcc_pkg;

  localparam int unsigned PidW  = 13;
  localparam int unsigned CcW   = 4;
  localparam int unsigned OffW  = 9;
  localparam int unsigned CtlW  = 2;
  localparam int unsigned EntryW = CcW + 1;
  localparam int unsigned PidDepth = 1 << PidW;
  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [7:0]      SyncByte = 8'h47;
  localparam logic [PidW-1:0] PidLo    = 13'h0020;
  localparam logic [PidW-1:0] PidHiA   = 13'h1FFA;
  localparam logic [PidW-1:0] PidLoB   = 13'h1FFC;
  localparam logic [PidW-1:0] PidHiB   = 13'h1FFE;
  localparam logic [CcW-1:0]  CcMax    = 4'hF;

  localparam logic [CtlW-1:0] CtlReserved = 2'b00;
  localparam logic [CtlW-1:0] CtlPayload  = 2'b01;
  localparam logic [CtlW-1:0] CtlAdaptOnly = 2'b10;
  localparam logic [CtlW-1:0] CtlBoth     = 2'b11;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StBadSync   = 3'd1,
    StTransErr  = 3'd2,
    StNoPayload = 3'd3,
    StPidRange  = 3'd4
  } status_e;

  typedef struct packed {
    status_e         status;
    logic [PidW-1:0] pid;
    logic            unit_start;
    logic [CtlW-1:0] ctl;
    logic [CcW-1:0]  cc;
    logic [OffW-1:0] offset;
  } item_t;

endpackage

// ===== design/ts_header_check_continuity.sv =====
// Takes one transport stream header per cycle, sustained while the output is not stalled,
// and returns one result per header in order via queue, read stage and output register.
// The front decodes and classifies each header into a two-entry queue. The back reads a
// per-PID entry from one 8192 x 5 RAM (seen bit and last count), decides loss and writes
// the entry back. A bypass of the latest write covers consecutive packets on the same PID.
// After reset the back clears the RAM one entry per cycle; in_stall_o is high until done.
// ----------------------------------------------------------------------------
// ts_header_check_continuity
// Transport stream header parser with per-PID continuity loss detection.
// ----------------------------------------------------------------------------
module ts_header_check_continuity #(
  parameter int unsigned QueueDepth = tshcc_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] header_word_i,
  input  logic [7:0]  adaptation_length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [12:0] packet_id_o,
  output logic        unit_start_o,
  output logic [1:0]  adaptation_control_o,
  output logic [3:0]  continuity_count_o,
  output logic [8:0]  payload_offset_o,
  output logic        loss_detected_o
);
  import tshcc_pkg::*;

  item_t front_item;
  item_t head_item;
  item_t out_item;
  logic  q_full;
  logic  q_valid;
  logic  pop;
  logic  clearing;
  logic  push;

  assign in_stall_o = q_full || clearing;
  assign push       = in_valid_i && !in_stall_o;

  tshcc_front u_front (
    .header_word_i       (header_word_i),
    .adaptation_length_i (adaptation_length_i),
    .item_o              (front_item)
  );

  tshcc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  tshcc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (head_item),
    .pop_o        (pop),
    .clearing_o   (clearing),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item),
    .out_loss_o   (loss_detected_o)
  );

  assign status_o             = out_item.status;
  assign packet_id_o          = out_item.pid;
  assign unit_start_o         = out_item.unit_start;
  assign adaptation_control_o = out_item.ctl;
  assign continuity_count_o   = out_item.cc;
  assign payload_offset_o     = out_item.offset;

endmodule

// ===== design/tshcc_front.sv =====
// ----------------------------------------------------------------------------
// tshcc_front
// Unpacks a header word and classifies the request: status and payload offset.
// ----------------------------------------------------------------------------
module tshcc_front (
  input  logic [31:0]          header_word_i,
  input  logic [7:0]           adaptation_length_i,
  output tshcc_pkg::item_t     item_o
);
  import tshcc_pkg::*;

  logic [7:0]      sync;
  logic            terr;
  logic [PidW-1:0] pid;
  logic [CtlW-1:0] ctl;
  logic            pid_ok;
  status_e         status;

  assign sync = header_word_i[31:24];
  assign terr = header_word_i[23];
  assign pid  = header_word_i[20:8];
  assign ctl  = header_word_i[5:4];

  assign pid_ok = ((pid >= PidLo) && (pid <= PidHiA)) ||
                  ((pid >= PidLoB) && (pid <= PidHiB));

  always_comb begin
    priority if (sync != SyncByte) begin
      status = StBadSync;
    end else if (terr) begin
      status = StTransErr;
    end else if ((ctl == CtlReserved) || (ctl == CtlAdaptOnly)) begin
      status = StNoPayload;
    end else if (!pid_ok) begin
      status = StPidRange;
    end else begin
      status = StOk;
    end
  end

  always_comb begin
    item_o.status     = status;
    item_o.pid        = pid;
    item_o.unit_start = header_word_i[22];
    item_o.ctl        = ctl;
    item_o.cc         = header_word_i[3:0];
    if ((status == StOk) && (ctl == CtlBoth)) begin
      item_o.offset = OffW'(adaptation_length_i) + OffW'(1);
    end else begin
      item_o.offset = '0;
    end
  end

endmodule

// ===== design/tshcc_queue.sv =====
// ----------------------------------------------------------------------------
// tshcc_queue
// Short register queue of classified requests between front and back.
// ----------------------------------------------------------------------------
`include "ts_header_check_continuity_macros.svh"

module tshcc_queue #(
  parameter int unsigned Depth = tshcc_pkg::QueueDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  tshcc_pkg::item_t item_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output tshcc_pkg::item_t item_o
);
  import tshcc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  `TSHCC_ASSERT_IMPLY(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= FullCnt)
  `TSHCC_ASSERT_IMPLY(a_no_push_full, clk_i, rst_ni, full_o, !push_i || pop_i)
  `TSHCC_ASSERT_IMPLY(a_no_pop_empty, clk_i, rst_ni, pop_i, cnt_q != '0)

endmodule

// ===== design/tshcc_ram.sv =====
// ----------------------------------------------------------------------------
// tshcc_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module tshcc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  assign rdata_o = rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

endmodule

// ===== design/tshcc_back.sv =====
// ----------------------------------------------------------------------------
// tshcc_back
// Per-PID continuity check: store read, loss decision, store update, output
// register. Clears the store after reset.
// ----------------------------------------------------------------------------
`include "ts_header_check_continuity_macros.svh"

module tshcc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  tshcc_pkg::item_t head_i,
  output logic             pop_o,
  output logic             clearing_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output tshcc_pkg::item_t out_item_o,
  output logic             out_loss_o
);
  import tshcc_pkg::*;

  logic              clearing_q;
  logic [PidW-1:0]   clr_idx_q;
  logic              adv;
  logic              s1_valid_q;
  item_t             s1_q;
  logic              out_valid_q;
  item_t             out_q;
  logic              out_loss_q;
  logic              byp_valid_q;
  logic [PidW-1:0]   byp_pid_q;
  logic [CcW-1:0]    byp_cc_q;
  logic [EntryW-1:0] rdata;
  logic              ram_we;
  logic [PidW-1:0]   ram_waddr;
  logic [EntryW-1:0] ram_wdata;
  logic              byp_hit;
  logic              seen;
  logic [CcW-1:0]    prev;
  logic              s1_ok;
  logic              item_we;
  logic              loss;

  assign adv   = !out_valid_q || !out_stall_i;
  assign pop_o = adv && !clearing_q && head_valid_i;

  assign byp_hit = byp_valid_q && (byp_pid_q == s1_q.pid);
  assign seen    = byp_hit ? 1'b1 : rdata[CcW];
  assign prev    = byp_hit ? byp_cc_q : rdata[CcW-1:0];
  assign s1_ok   = (s1_q.status == StOk);
  assign item_we = adv && s1_valid_q && s1_ok;
  assign loss    = s1_ok && seen && (prev != CcMax) && (s1_q.cc != '0) &&
                   ({1'b0, s1_q.cc} != ({1'b0, prev} + (CcW+1)'(1)));

  always_comb begin
    if (clearing_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx_q;
      ram_wdata = '0;
    end else begin
      ram_we    = item_we;
      ram_waddr = s1_q.pid;
      ram_wdata = {1'b1, s1_q.cc};
    end
  end

  tshcc_ram #(
    .Width (EntryW),
    .Depth (PidDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (pop_o),
    .raddr_i (head_i.pid),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q  <= 1'b1;
      clr_idx_q   <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      byp_valid_q <= 1'b0;
    end else begin
      if (clearing_q) begin
        clr_idx_q <= clr_idx_q + PidW'(1);
        if (clr_idx_q == '1) begin
          clearing_q <= 1'b0;
        end
      end
      if (adv) begin
        s1_valid_q  <= pop_o;
        out_valid_q <= s1_valid_q;
      end
      if (item_we) begin
        byp_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_q <= head_i;
    end
    if (adv) begin
      out_q      <= s1_q;
      out_loss_q <= loss;
    end
    if (item_we) begin
      byp_pid_q <= s1_q.pid;
      byp_cc_q  <= s1_q.cc;
    end
  end

  assign clearing_o  = clearing_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign out_loss_o  = out_loss_q;

  `TSHCC_ASSERT_IMPLY(a_no_item_write_clear, clk_i, rst_ni, clearing_q, !item_we && !pop_o)
  `TSHCC_ASSERT_IMPLY(a_loss_only_ok, clk_i, rst_ni, out_valid_q && out_loss_q,
                      out_q.status == StOk)
  `TSHCC_ASSERT_NEXT(a_clear_wraps, clk_i, rst_ni, clearing_q && (clr_idx_q == '1),
                     !clearing_q && (clr_idx_q == '0))
  `TSHCC_ASSERT_IMPLY(a_hit_only_after_write, clk_i, rst_ni, byp_hit, !clearing_q)

endmodule

// ===== tb/ts_header_check_continuity_test.sv =====
// ----------------------------------------------------------------------------
// Transport stream header checker testbench
// Drives packet headers through the valid/stall input, predicts status,
// payload offset and per-PID continuity loss, and checks every result in
// order. Directed corner cases first, then mostly well-formed streams on a
// small PID set with random breaks, noise, random idling and a long
// output hold-off.
// ----------------------------------------------------------------------------
module ts_header_check_continuity_test;
  import tshcc_pkg::*;

  localparam int unsigned RandomRequests = 1500;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned CycleLimit = 200000;

  typedef struct packed {
    logic [2:0]      status;
    logic [PidW-1:0] pid;
    logic            unit_start;
    logic [CtlW-1:0] ctl;
    logic [CcW-1:0]  cc;
    logic [OffW-1:0] offset;
    logic            loss;
  } verdict_t;

  class ts_header_scoreboard;
    bit [CcW-1:0] last_cc [PidDepth];
    bit           seen [PidDepth];
    verdict_t     due_q [$];
    int unsigned  n_requests, n_accepted, n_loss, n_rejected, n_checked;
    int unsigned  n_mismatch, n_unexpected;

    function void note_request(logic [31:0] hw, logic [7:0] alen);
      verdict_t v;
      v.pid        = hw[20:8];
      v.unit_start = hw[22];
      v.ctl        = hw[5:4];
      v.cc         = hw[3:0];
      v.offset     = '0;
      v.loss       = 1'b0;
      if (hw[31:24] != SyncByte) v.status = StBadSync;
      else if (hw[23]) v.status = StTransErr;
      else if (v.ctl == CtlReserved || v.ctl == CtlAdaptOnly) v.status = StNoPayload;
      else if (!((v.pid >= PidLo && v.pid <= PidHiA) || (v.pid >= PidLoB && v.pid <= PidHiB)))
        v.status = StPidRange;
      else v.status = StOk;
      if (v.status == StOk) begin
        if (v.ctl == CtlBoth) v.offset = OffW'(alen) + 9'd1;
        if (seen[v.pid] && (5'(v.cc) != 5'(last_cc[v.pid]) + 5'd1) &&
            last_cc[v.pid] != CcMax && v.cc != '0)
          v.loss = 1'b1;
        last_cc[v.pid] = v.cc;
        seen[v.pid]    = 1'b1;
        n_accepted++;
        if (v.loss) n_loss++;
      end else begin
        n_rejected++;
      end
      n_requests++;
      due_q.push_back(v);
    endfunction

    function void check_result(verdict_t got);
      verdict_t want;
      if (due_q.size() == 0) begin
        n_unexpected++;
        if (n_unexpected + n_mismatch <= 10)
          $display("unexpected result: st=%0d pid=%h cc=%0d", got.status, got.pid, got.cc);
        return;
      end
      want = due_q.pop_front();
      n_checked++;
      if (got.status !== want.status || got.pid !== want.pid ||
          got.unit_start !== want.unit_start || got.ctl !== want.ctl ||
          got.cc !== want.cc || got.offset !== want.offset || got.loss !== want.loss) begin
        n_mismatch++;
        if (n_unexpected + n_mismatch <= 10) begin
          $display("mismatch on result %0d", n_checked);
          $display("  exp st=%0d pid=%h pusi=%b ctl=%0d cc=%0d off=%0d loss=%b",
                   want.status, want.pid, want.unit_start, want.ctl, want.cc,
                   want.offset, want.loss);
          $display("  got st=%0d pid=%h pusi=%b ctl=%0d cc=%0d off=%0d loss=%b",
                   got.status, got.pid, got.unit_start, got.ctl, got.cc,
                   got.offset, got.loss);
        end
      end
    endfunction

    function int unsigned pending();
      return due_q.size();
    endfunction

    function int unsigned failures();
      return n_mismatch + n_unexpected;
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] header_word_i = '0;
  logic [7:0]  adaptation_length_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [12:0] packet_id_o;
  logic        unit_start_o;
  logic [1:0]  adaptation_control_o;
  logic [3:0]  continuity_count_o;
  logic [8:0]  payload_offset_o;
  logic        loss_detected_o;

  ts_header_scoreboard sb = new();
  logic        hold_req = 1'b0;
  bit          hold_done;
  int unsigned cycle_n;
  bit [CcW-1:0] next_cc [PidDepth];

  ts_header_check_continuity dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .header_word_i        (header_word_i),
    .adaptation_length_i  (adaptation_length_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .status_o             (status_o),
    .packet_id_o          (packet_id_o),
    .unit_start_o         (unit_start_o),
    .adaptation_control_o (adaptation_control_o),
    .continuity_count_o   (continuity_count_o),
    .payload_offset_o     (payload_offset_o),
    .loss_detected_o      (loss_detected_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_n, sb.pending());
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result('{status_o, packet_id_o, unit_start_o, adaptation_control_o,
                        continuity_count_o, payload_offset_o, loss_detected_o});
  end

  // receiver: stall pattern changes per window; one long hold-off on request
  initial begin
    int unsigned mode;
    int unsigned span;
    @(posedge clk_i);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 60);
      repeat (span) begin
        if (hold_req && !hold_done) break;
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= ~out_stall_i;
        endcase
        @(posedge clk_i);
      end
    end
  end

  function automatic logic [31:0] make_header(logic [7:0] sync, logic terr, logic pusi,
                                               logic [PidW-1:0] pid, logic [CtlW-1:0] ctl,
                                               logic [CcW-1:0] cc);
    return {sync, terr, pusi, 1'($urandom), pid, 2'($urandom), ctl, cc};
  endfunction

  task automatic send_request(logic [31:0] hw, logic [7:0] alen);
    header_word_i       <= hw;
    adaptation_length_i <= alen;
    in_valid_i          <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(hw, alen);
  endtask

  task automatic pause_sender(int unsigned n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  initial begin
    logic [PidW-1:0] pid_pool [8];
    logic [PidW-1:0] pid;
    logic [PidW-1:0] last_pid;
    logic [CcW-1:0]  cc;
    logic [CtlW-1:0] ctl;
    logic [31:0]     hw;
    int unsigned     kind;
    int unsigned     burst_left;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // continuity rule on one PID, back to back
    send_request(make_header(SyncByte, 1'b0, 1'b1, PidLo, CtlPayload, 4'd5), 8'h00);
    send_request(make_header(SyncByte, 1'b0, 1'b0, PidLo, CtlPayload, 4'd6), 8'h00);
    send_request(make_header(SyncByte, 1'b0, 1'b0, PidLo, CtlPayload, 4'd6), 8'h00);
    send_request(make_header(SyncByte, 1'b0, 1'b0, PidLo, CtlPayload, 4'd15), 8'h00);
    send_request(make_header(SyncByte, 1'b0, 1'b0, PidLo, CtlPayload, 4'd3), 8'h00);
    send_request(make_header(SyncByte, 1'b0, 1'b0, PidLo, CtlPayload, 4'd0), 8'h00);
    // rejected packet leaves the PID alone
    send_request(make_header(SyncByte, 1'b0, 1'b0, PidLo, CtlAdaptOnly, 4'd9), 8'h00);
    send_request(make_header(SyncByte, 1'b0, 1'b0, PidLo, CtlPayload, 4'd1), 8'h00);
    // range ends and offset extremes
    send_request(make_header(SyncByte, 1'b0, 1'b1, PidHiA, CtlBoth, 4'd7), 8'hFF);
    send_request(make_header(SyncByte, 1'b0, 1'b0, PidLoB, CtlBoth, 4'd2), 8'h00);
    send_request(make_header(SyncByte, 1'b0, 1'b1, PidHiB, CtlPayload, 4'd15), 8'hAA);
    send_request(make_header(SyncByte, 1'b0, 1'b0, PidHiB, CtlBoth, 4'd0), 8'h80);
    send_request(make_header(SyncByte, 1'b0, 1'b0, PidHiA + 13'd1, CtlPayload, 4'd1), 8'h00);
    send_request(make_header(SyncByte, 1'b0, 1'b0, PidLo - 13'd1, CtlPayload, 4'd1), 8'h00);
    send_request(make_header(SyncByte, 1'b0, 1'b0, 13'h0000, CtlBoth, 4'd1), 8'h10);
    send_request(make_header(SyncByte, 1'b0, 1'b0, 13'h1FFF, CtlBoth, 4'd1), 8'h10);
    // check order: sync, error bit, payload, PID
    send_request(32'h00FF_FFFF, 8'hFF);
    send_request(32'h0000_0000, 8'h00);
    send_request(make_header(8'hFF, 1'b0, 1'b0, PidLo, CtlPayload, 4'd2), 8'h00);
    send_request(make_header(8'h46, 1'b1, 1'b0, PidLo, CtlPayload, 4'd2), 8'h00);
    send_request(make_header(SyncByte, 1'b1, 1'b1, 13'h1FFF, CtlReserved, 4'd2), 8'h00);
    send_request(make_header(SyncByte, 1'b0, 1'b0, PidLo, CtlReserved, 4'd2), 8'h00);
    send_request(make_header(SyncByte, 1'b0, 1'b0, 13'h1FFF, CtlAdaptOnly, 4'd2), 8'h00);

    pid_pool[0] = PidLo;
    pid_pool[1] = PidHiA;
    pid_pool[2] = PidLoB;
    pid_pool[3] = PidHiB;
    for (int i = 4; i < 8; i++) pid_pool[i] = PidW'($urandom_range(PidLo, PidHiA));
    last_pid = PidLo;
    burst_left = 0;

    for (int unsigned n = 0; n < RandomRequests; n++) begin
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 8));
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                 : $urandom_range(1, 20);
      end
      burst_left--;
      if (n == RandomRequests / 3) hold_req <= 1'b1;

      kind = $urandom_range(0, 99);
      pid  = PidW'($urandom);
      if (kind < 80) begin
        if ($urandom_range(0, 2) != 0) pid = last_pid;
        else pid = pid_pool[$urandom_range(0, 7)];
        if ($urandom_range(0, 9) == 0) pid = PidW'($urandom_range(PidLo, PidHiA));
        cc = ($urandom_range(0, 4) != 0) ? next_cc[pid] : CcW'($urandom);
        next_cc[pid] = cc + 4'd1;
        ctl = $urandom_range(0, 1) ? CtlBoth : CtlPayload;
        hw = make_header(SyncByte, 1'b0, 1'($urandom), pid, ctl, cc);
        last_pid = pid;
      end else if (kind < 85) begin
        hw = $urandom;
      end else if (kind < 90) begin
        hw = make_header(SyncByte, 1'b1, 1'($urandom), pid, CtlW'($urandom), CcW'($urandom));
      end else if (kind < 95) begin
        ctl = $urandom_range(0, 1) ? CtlReserved : CtlAdaptOnly;
        hw = make_header(SyncByte, 1'b0, 1'($urandom), pid, ctl, CcW'($urandom));
      end else begin
        hw = make_header(SyncByte, 1'b0, 1'($urandom), pid, CtlW'($urandom), CcW'($urandom));
      end
      send_request(hw, 8'($urandom));
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("%0d headers checked: %0d accepted (%0d flagged as continuity loss), %0d rejected",
             sb.n_checked, sb.n_accepted, sb.n_loss, sb.n_rejected);
    $display("output held off once for %0d cycles; %0d mismatches, %0d unexpected results",
             HoldCycles, sb.n_mismatch, sb.n_unexpected);
    if (sb.failures() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
